/* rtl/tehc_pkg.sv */
package tehc_pkg;

  // Widths of the axis counters and of the brake and coast timer.
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned TIMER_WIDTH = 24;
  localparam int unsigned CFG_WIDTH   = (COUNT_WIDTH > TIMER_WIDTH) ? COUNT_WIDTH : TIMER_WIDTH;

  // Stream payload widths.
  localparam int unsigned IN_BITS      = 9;
  localparam int unsigned IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS     = 2 + 2 + COUNT_WIDTH + COUNT_WIDTH + 1;
  localparam int unsigned OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_BITS;

  // Register reset values.
  localparam logic [COUNT_WIDTH-1:0] TARGET_RESET = COUNT_WIDTH'(16'h2800);
  localparam logic [TIMER_WIDTH-1:0] BRAKE_RESET  = TIMER_WIDTH'(200000);
  localparam logic [TIMER_WIDTH-1:0] COAST_RESET  = TIMER_WIDTH'(50000);

  // Register indices on the configuration port.
  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_BRAKE  = 2'd1;
  localparam logic [1:0] REG_COAST  = 2'd2;

  // Operation codes.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_HOME   = 2'd1;
  localparam logic [1:0] OP_CENTER = 2'd2;

  // H-bridge drive codes.
  localparam logic [1:0] DRV_COAST  = 2'd0;
  localparam logic [1:0] DRV_TARGET = 2'd1;
  localparam logic [1:0] DRV_LIMIT  = 2'd2;
  localparam logic [1:0] DRV_BRAKE  = 2'd3;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_SEEK    = 8'b0000_0010,
    PH_BRAKE_A = 8'b0000_0100,
    PH_COAST_A = 8'b0000_1000,
    PH_OUT     = 8'b0001_0000,
    PH_BRAKE_B = 8'b0010_0000,
    PH_COAST_B = 8'b0100_0000,
    PH_CENTER  = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] target;
    logic [TIMER_WIDTH-1:0] brake;
    logic [TIMER_WIDTH-1:0] coast;
  } cfg_t;

  typedef struct packed {
    logic       fault_n;
    logic       limit2_n;
    logic       limit1_n;
    logic       enc_b2;
    logic       enc_a2;
    logic       enc_b1;
    logic       enc_a1;
    logic [1:0] op;
  } in_item_t;

  typedef struct packed {
    logic [1:0] op;
    logic       limit1_n;
    logic       limit2_n;
    logic       fault_n;
  } seq_in_t;

endpackage

/* rtl/tehc_counter.sv */
module tehc_counter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             limit_n_i,
  input  logic                             enc_a_i,
  input  logic                             enc_b_i,
  output logic [tehc_pkg::COUNT_WIDTH-1:0] count_d_o
);

  logic [tehc_pkg::COUNT_WIDTH-1:0] count_q;
  logic                             armed_q, armed_d;
  logic [tehc_pkg::COUNT_WIDTH-1:0] base;

  // The limit clear comes first, then a falling edge of A counts.
  always_comb begin
    base      = limit_n_i ? count_q : '0;
    count_d_o = base;
    armed_d   = armed_q;
    if (enc_a_i) begin
      armed_d = 1'b1;
    end else if (armed_q) begin
      armed_d   = 1'b0;
      count_d_o = enc_b_i ? base - tehc_pkg::COUNT_WIDTH'(1)
                          : base + tehc_pkg::COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      armed_q <= 1'b0;
    end else if (en_i) begin
      count_q <= count_d_o;
      armed_q <= armed_d;
    end
  end

  a_limit_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && !limit_n_i && !(armed_q && !enc_a_i)) |=> (count_q == '0))
    else $error("limit did not clear the axis count");

endmodule

/* rtl/tehc_sequencer.sv */
module tehc_sequencer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  tehc_pkg::cfg_t                   cfg_i,
  input  tehc_pkg::seq_in_t                seq_i,
  input  logic [tehc_pkg::COUNT_WIDTH-1:0] count1_i,
  input  logic [tehc_pkg::COUNT_WIDTH-1:0] count2_i,
  output logic [1:0]                       drive1_d_o,
  output logic [1:0]                       drive2_d_o,
  output logic                             busy_d_o
);

  tehc_pkg::phase_e                 phase_q, phase_d, ph;
  logic [tehc_pkg::TIMER_WIDTH-1:0] timer_q, timer_d, tmr;
  logic [1:0]                       dirs_q, dirs_d, dirs;
  logic [3:0]                       drive_q, drive_d;
  logic                             wr1, wr2, act1, act2;
  logic [1:0]                       code1, code2;

  always_comb begin
    ph   = phase_q;
    tmr  = timer_q;
    dirs = dirs_q;
    // A start is taken only in idle and its first step runs in the same tick.
    if (phase_q == tehc_pkg::PH_IDLE) begin
      if (seq_i.op == tehc_pkg::OP_HOME) begin
        ph = tehc_pkg::PH_SEEK;
      end else if (seq_i.op == tehc_pkg::OP_CENTER) begin
        dirs   = {count2_i > cfg_i.target, count1_i > cfg_i.target};
        tmr    = '0;
        tmr[0] = (count1_i == cfg_i.target);
        tmr[1] = (count2_i == cfg_i.target);
        ph     = tehc_pkg::PH_CENTER;
      end
    end

    phase_d = ph;
    timer_d = tmr;
    dirs_d  = dirs;
    wr1     = 1'b0;
    wr2     = 1'b0;
    code1   = tehc_pkg::DRV_COAST;
    code2   = tehc_pkg::DRV_COAST;
    act1    = 1'b0;
    act2    = 1'b0;

    unique case (ph)
      tehc_pkg::PH_SEEK: begin
        if (seq_i.limit1_n || seq_i.limit2_n) begin
          wr1   = 1'b1;
          wr2   = 1'b1;
          code1 = seq_i.limit1_n ? tehc_pkg::DRV_LIMIT : tehc_pkg::DRV_BRAKE;
          code2 = seq_i.limit2_n ? tehc_pkg::DRV_LIMIT : tehc_pkg::DRV_BRAKE;
        end else begin
          wr1     = 1'b1;
          wr2     = 1'b1;
          code1   = tehc_pkg::DRV_BRAKE;
          code2   = tehc_pkg::DRV_BRAKE;
          timer_d = cfg_i.brake;
          phase_d = tehc_pkg::PH_BRAKE_A;
        end
      end
      tehc_pkg::PH_BRAKE_A, tehc_pkg::PH_BRAKE_B: begin
        if (tmr != '0) begin
          timer_d = tmr - tehc_pkg::TIMER_WIDTH'(1);
        end else begin
          wr1     = 1'b1;
          wr2     = 1'b1;
          timer_d = cfg_i.coast;
          phase_d = (ph == tehc_pkg::PH_BRAKE_A) ? tehc_pkg::PH_COAST_A
                                                 : tehc_pkg::PH_COAST_B;
        end
      end
      tehc_pkg::PH_COAST_A, tehc_pkg::PH_COAST_B: begin
        if (tmr != '0) begin
          timer_d = tmr - tehc_pkg::TIMER_WIDTH'(1);
        end else begin
          phase_d = (ph == tehc_pkg::PH_COAST_A) ? tehc_pkg::PH_OUT : tehc_pkg::PH_IDLE;
        end
      end
      tehc_pkg::PH_OUT: begin
        act1  = count1_i < cfg_i.target;
        act2  = count2_i < cfg_i.target;
        wr1   = 1'b1;
        wr2   = 1'b1;
        if (act1 || act2) begin
          code1 = act1 ? tehc_pkg::DRV_TARGET : tehc_pkg::DRV_BRAKE;
          code2 = act2 ? tehc_pkg::DRV_TARGET : tehc_pkg::DRV_BRAKE;
        end else begin
          code1   = tehc_pkg::DRV_BRAKE;
          code2   = tehc_pkg::DRV_BRAKE;
          timer_d = cfg_i.brake;
          phase_d = tehc_pkg::PH_BRAKE_B;
        end
      end
      tehc_pkg::PH_CENTER: begin
        // Hold flags for axes that started on the target sit in timer bits 0 and 1.
        act1 = !tmr[0] && (dirs[0] ? count1_i > cfg_i.target : count1_i < cfg_i.target);
        act2 = !tmr[1] && (dirs[1] ? count2_i > cfg_i.target : count2_i < cfg_i.target);
        if (act1 || act2) begin
          wr1   = !tmr[0];
          wr2   = !tmr[1];
          code1 = act1 ? (dirs[0] ? tehc_pkg::DRV_LIMIT : tehc_pkg::DRV_TARGET)
                       : tehc_pkg::DRV_BRAKE;
          code2 = act2 ? (dirs[1] ? tehc_pkg::DRV_LIMIT : tehc_pkg::DRV_TARGET)
                       : tehc_pkg::DRV_BRAKE;
        end else begin
          wr1     = 1'b1;
          wr2     = 1'b1;
          code1   = tehc_pkg::DRV_BRAKE;
          code2   = tehc_pkg::DRV_BRAKE;
          timer_d = cfg_i.brake;
          phase_d = tehc_pkg::PH_BRAKE_B;
        end
      end
      default: begin
      end
    endcase

    // A driver fault freezes the bridge pins; the sequence itself goes on.
    drive_d = drive_q;
    if (seq_i.fault_n && wr1) begin
      drive_d[1:0] = code1;
    end
    if (seq_i.fault_n && wr2) begin
      drive_d[3:2] = code2;
    end
  end

  assign drive1_d_o = drive_d[1:0];
  assign drive2_d_o = drive_d[3:2];
  assign busy_d_o   = (phase_d != tehc_pkg::PH_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tehc_pkg::PH_IDLE;
      timer_q <= '0;
      dirs_q  <= '0;
      drive_q <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      dirs_q  <= dirs_d;
      drive_q <= drive_d;
    end
  end

  a_fault_holds_drive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && !seq_i.fault_n) |=> $stable(drive_q))
    else $error("drive changed during a bridge fault");

  a_brake_counts_down : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && (phase_q == tehc_pkg::PH_BRAKE_A || phase_q == tehc_pkg::PH_BRAKE_B)
     && timer_q != '0)
    |=> (timer_q == $past(timer_q) - tehc_pkg::TIMER_WIDTH'(1)))
    else $error("brake timer did not count down");

endmodule

/* rtl/two_axis_encoder_homing_controller.sv */
// Two-axis encoder counter with homing and recenter sequencing.
// Each transfer on the slave stream is one tick: an op code, the two encoder
// channel pairs, both active-low limit switches and the bridge fault line.
// Every tick yields exactly one transfer on the master stream carrying both
// bridge drive codes, both axis counts after the tick and a busy flag.
// Configuration (target count, brake and coast tick counts) is written through
// the cfg port; the user must write it only while no sequence runs, as the block
// itself does not enforce this. Writes take effect at once.
// The block is a two-stage pipeline: an input register, then the counters
// and the homing sequencer, whose results are loaded into the output
// register. A tick's result passes through the input register and then the
// output register before it is presented on the master side, and the block
// sustains one tick per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its result and the
// input register takes one more tick before the slave side is held off.
// Reset clears both counts, the sequencer to idle with both bridges in coast,
// empties the pipeline and reloads the configuration registers with their
// defaults.
module two_axis_encoder_homing_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Fields from bit 0: op[1:0], enc_a1, enc_b1, enc_a2, enc_b2, limit1_n,
  // limit2_n, fault_n, zero padding.
  input  logic [tehc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: drive1[1:0], drive2[1:0], pos1, pos2, busy_res,
  // zero padding.
  output logic [tehc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [tehc_pkg::CFG_WIDTH-1:0]      cfg_wdata_i
);

  tehc_pkg::cfg_t                   cfg_q;
  tehc_pkg::in_item_t               in_q;
  tehc_pkg::seq_in_t                seq_in;
  logic                             in_vld_q, in_vld_d;
  logic                             out_vld_q, out_vld_d;
  logic                             in_fire, step;
  logic [tehc_pkg::COUNT_WIDTH-1:0] count1_d, count2_d;
  logic [1:0]                       drive1_d, drive2_d;
  logic                             busy_d;
  logic [tehc_pkg::OUT_BITS-1:0]    out_q;

  // The state update happens when the registered tick moves into the output
  // register, which is free or being emptied in the same cycle.
  assign step          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || step;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cfg_q     <= '{target: tehc_pkg::TARGET_RESET,
                     brake:  tehc_pkg::BRAKE_RESET,
                     coast:  tehc_pkg::COAST_RESET};
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tehc_pkg::REG_TARGET: cfg_q.target <= cfg_wdata_i[tehc_pkg::COUNT_WIDTH-1:0];
          tehc_pkg::REG_BRAKE:  cfg_q.brake  <= cfg_wdata_i[tehc_pkg::TIMER_WIDTH-1:0];
          tehc_pkg::REG_COAST:  cfg_q.coast  <= cfg_wdata_i[tehc_pkg::TIMER_WIDTH-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= s_axis_tdata[tehc_pkg::IN_BITS-1:0];
    end
    if (step) begin
      out_q <= {busy_d, count2_d, count1_d, drive2_d, drive1_d};
    end
  end

  tehc_counter u_counter1 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (step),
    .limit_n_i (in_q.limit1_n),
    .enc_a_i   (in_q.enc_a1),
    .enc_b_i   (in_q.enc_b1),
    .count_d_o (count1_d)
  );

  tehc_counter u_counter2 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (step),
    .limit_n_i (in_q.limit2_n),
    .enc_a_i   (in_q.enc_a2),
    .enc_b_i   (in_q.enc_b2),
    .count_d_o (count2_d)
  );

  assign seq_in = '{op:       in_q.op,
                    limit1_n: in_q.limit1_n,
                    limit2_n: in_q.limit2_n,
                    fault_n:  in_q.fault_n};

  tehc_sequencer u_sequencer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (step),
    .cfg_i      (cfg_q),
    .seq_i      (seq_in),
    .count1_i   (count1_d),
    .count2_i   (count2_d),
    .drive1_d_o (drive1_d),
    .drive2_d_o (drive2_d),
    .busy_d_o   (busy_d)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{tehc_pkg::OUT_PAD_W{1'b0}}, out_q};

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_vld_q || !out_vld_q) |-> s_axis_tready)
    else $error("slave side held off with room in the pipeline");

  a_tick_registered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_vld_q)
    else $error("accepted tick lost from the input register");

  a_step_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("stepped tick did not reach the output register");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import tehc_pkg::*;

  // The op field is two bits wide, so a fourth code exists; the block treats
  // it as a plain tick.
  localparam logic [1:0] OP_SPARE = 2'd3;

  // Length of the long receiver hold-off, in clock cycles.
  localparam int LONG_HOLD = 300;
  // Cycles allowed after the last result before the configuration is touched
  // or the run is closed. The pipeline is two stages deep.
  localparam int DRAIN_CYCLES = 6;

  // Everything the controller remembers from one tick to the next.
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] cnt1;
    logic [COUNT_WIDTH-1:0] cnt2;
    logic                   arm1;
    logic                   arm2;
    phase_e                 ph;
    logic [TIMER_WIDTH-1:0] timer;
    logic [1:0]             dirs;
    logic [1:0]             drv1;
    logic [1:0]             drv2;
  } axis_state_t;

  // One result as it travels on the master stream, last field lowest.
  typedef struct packed {
    logic                   busy;
    logic [COUNT_WIDTH-1:0] pos2;
    logic [COUNT_WIDTH-1:0] pos1;
    logic [1:0]             drive2;
    logic [1:0]             drive1;
  } status_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  // Fields from bit 0: op[1:0], enc_a1, enc_b1, enc_a2, enc_b2, limit1_n,
  // limit2_n, fault_n, zero padding.
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // Fields from bit 0: drive1[1:0], drive2[1:0], pos1, pos2, busy_res,
  // zero padding.
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [1:0]             cfg_idx_i     = REG_TARGET;
  logic [CFG_WIDTH-1:0]   cfg_wdata_i   = '0;

  // Ticks waiting to be offered, and the statuses still owed by the block.
  in_item_t    tick_q[$];
  status_t     status_q[$];

  // The stimulus side keeps its own copy of the controller so that it can
  // steer sequences to completion; the checking side advances its copy only
  // on accepted transfers.
  axis_state_t plan_st;
  axis_state_t pred_st;
  cfg_t        model_cfg;

  logic        in_fire      = 1'b0;
  int          idle_pct     = 0;
  int          stall_pct    = 0;
  int          holds_asked  = 0;
  int          holds_served = 0;
  int          hold_left    = 0;
  int          error_cnt    = 0;

  two_axis_encoder_homing_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Behaviour of the controller, one tick at a time.
  // ---------------------------------------------------------------------

  function automatic axis_state_t reset_state();
    axis_state_t s;
    s    = '0;
    s.ph = PH_IDLE;
    return s;
  endfunction

  // A held limit clears the count first; a falling edge of channel A then
  // counts up with B low and down with B high.
  function automatic logic [COUNT_WIDTH:0] axis_count(logic [COUNT_WIDTH:0] ac, logic lim_n,
                                                      logic a, logic b);
    logic                   armed;
    logic [COUNT_WIDTH-1:0] cnt;
    {armed, cnt} = ac;
    if (!lim_n) cnt = '0;
    if (a) begin
      armed = 1'b1;
    end else if (armed) begin
      armed = 1'b0;
      cnt   = b ? cnt - 1'b1 : cnt + 1'b1;
    end
    return {armed, cnt};
  endfunction

  function automatic axis_state_t start_brake(axis_state_t s, logic drive_ok,
                                              logic [TIMER_WIDTH-1:0] ticks, phase_e next_ph);
    if (drive_ok) begin
      s.drv1 = DRV_BRAKE;
      s.drv2 = DRV_BRAKE;
    end
    s.timer = ticks;
    s.ph    = next_ph;
    return s;
  endfunction

  // A low fault line freezes the bridge codes only; everything else moves on.
  function automatic axis_state_t homing_tick(axis_state_t s, in_item_t it, cfg_t c);
    logic go1;
    logic go2;
    {s.arm1, s.cnt1} = axis_count({s.arm1, s.cnt1}, it.limit1_n, it.enc_a1, it.enc_b1);
    {s.arm2, s.cnt2} = axis_count({s.arm2, s.cnt2}, it.limit2_n, it.enc_a2, it.enc_b2);

    // Starts are honoured only from idle and their first step runs at once.
    if (s.ph == PH_IDLE) begin
      if (it.op == OP_HOME) begin
        s.ph = PH_SEEK;
      end else if (it.op == OP_CENTER) begin
        s.dirs  = {s.cnt2 > c.target, s.cnt1 > c.target};
        // An axis already on target is left alone; its flag lives in the timer.
        s.timer = {{(TIMER_WIDTH-2){1'b0}}, s.cnt2 == c.target, s.cnt1 == c.target};
        s.ph    = PH_CENTER;
      end
    end

    case (s.ph)
      PH_SEEK: begin
        if (it.limit1_n || it.limit2_n) begin
          if (it.fault_n) begin
            s.drv1 = it.limit1_n ? DRV_LIMIT : DRV_BRAKE;
            s.drv2 = it.limit2_n ? DRV_LIMIT : DRV_BRAKE;
          end
        end else begin
          s = start_brake(s, it.fault_n, c.brake, PH_BRAKE_A);
        end
      end
      PH_BRAKE_A, PH_BRAKE_B: begin
        if (s.timer != 0) begin
          s.timer = s.timer - 1'b1;
        end else begin
          if (it.fault_n) begin
            s.drv1 = DRV_COAST;
            s.drv2 = DRV_COAST;
          end
          s.timer = c.coast;
          s.ph    = (s.ph == PH_BRAKE_A) ? PH_COAST_A : PH_COAST_B;
        end
      end
      PH_COAST_A, PH_COAST_B: begin
        if (s.timer != 0) begin
          s.timer = s.timer - 1'b1;
        end else begin
          s.ph = (s.ph == PH_COAST_A) ? PH_OUT : PH_IDLE;
        end
      end
      PH_OUT: begin
        go1 = s.cnt1 < c.target;
        go2 = s.cnt2 < c.target;
        if (go1 || go2) begin
          if (it.fault_n) begin
            s.drv1 = go1 ? DRV_TARGET : DRV_BRAKE;
            s.drv2 = go2 ? DRV_TARGET : DRV_BRAKE;
          end
        end else begin
          s = start_brake(s, it.fault_n, c.brake, PH_BRAKE_B);
        end
      end
      PH_CENTER: begin
        go1 = !s.timer[0] && (s.dirs[0] ? s.cnt1 > c.target : s.cnt1 < c.target);
        go2 = !s.timer[1] && (s.dirs[1] ? s.cnt2 > c.target : s.cnt2 < c.target);
        if (go1 || go2) begin
          if (it.fault_n && !s.timer[0]) begin
            s.drv1 = go1 ? (s.dirs[0] ? DRV_LIMIT : DRV_TARGET) : DRV_BRAKE;
          end
          if (it.fault_n && !s.timer[1]) begin
            s.drv2 = go2 ? (s.dirs[1] ? DRV_LIMIT : DRV_TARGET) : DRV_BRAKE;
          end
        end else begin
          s = start_brake(s, it.fault_n, c.brake, PH_BRAKE_B);
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic status_t status_of(axis_state_t s);
    status_t st;
    st.drive1 = s.drv1;
    st.drive2 = s.drv2;
    st.pos1   = s.cnt1;
    st.pos2   = s.cnt2;
    st.busy   = (s.ph != PH_IDLE);
    return st;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus shaping.
  // ---------------------------------------------------------------------

  function automatic in_item_t tick_of(logic [1:0] op, logic a1, logic b1, logic a2, logic b2,
                                       logic l1, logic l2, logic f);
    in_item_t it;
    it.op       = op;
    it.enc_a1   = a1;
    it.enc_b1   = b1;
    it.enc_a2   = a2;
    it.enc_b2   = b2;
    it.limit1_n = l1;
    it.limit2_n = l2;
    it.fault_n  = f;
    return it;
  endfunction

  // Idle drift of an axis, biased upwards so that counts seldom wrap below
  // zero: +1, -1 or 0.
  function automatic int wander();
    int r;
    r = $urandom_range(5);
    if (r < 2) return 0;
    if (r < 5) return 1;
    return -1;
  endfunction

  // Channel levels {A, B} that move an axis by one step every second tick.
  function automatic logic [1:0] quad_levels(logic armed, int move);
    logic b;
    b = 1'($urandom_range(1));
    if (move == 0) return {armed, b};
    if (armed) return {1'b0, move < 0};
    return {1'b1, b};
  endfunction

  // A crude mechanical plant: motors follow the sequencer, limits close while
  // seeking, and counts move towards the target while driving out.
  function automatic in_item_t plant_tick(axis_state_t s, cfg_t c, bit may_start);
    in_item_t it;
    int       r;
    int       lim_pct;
    int       mv1;
    int       mv2;
    it.op = OP_TICK;
    if (may_start && s.ph == PH_IDLE) begin
      r = $urandom_range(99);
      if (r < 5) begin
        it.op = OP_HOME;
      end else if (r < 10 && int'(s.cnt1) <= int'(c.target) + 64 &&
                   int'(s.cnt2) <= int'(c.target) + 64) begin
        it.op = OP_CENTER;
      end
    end
    it.fault_n = ($urandom_range(99) >= 5);
    case (s.ph)
      PH_SEEK:           lim_pct = 60;
      PH_OUT, PH_CENTER: lim_pct = 0;
      default:           lim_pct = 10;
    endcase
    it.limit1_n = ($urandom_range(99) >= lim_pct);
    it.limit2_n = ($urandom_range(99) >= lim_pct);
    mv1 = wander();
    mv2 = wander();
    if (s.ph == PH_OUT) begin
      mv1 = (s.cnt1 < c.target) ? 1 : 0;
      mv2 = (s.cnt2 < c.target) ? 1 : 0;
    end else if (s.ph == PH_CENTER) begin
      if (!s.timer[0]) begin
        mv1 = s.dirs[0] ? ((s.cnt1 > c.target) ? -1 : 0) : ((s.cnt1 < c.target) ? 1 : 0);
      end
      if (!s.timer[1]) begin
        mv2 = s.dirs[1] ? ((s.cnt2 > c.target) ? -1 : 0) : ((s.cnt2 < c.target) ? 1 : 0);
      end
    end
    {it.enc_a1, it.enc_b1} = quad_levels(s.arm1, mv1);
    {it.enc_a2, it.enc_b2} = quad_levels(s.arm2, mv2);
    return it;
  endfunction

  // Unshaped ticks. A recenter from a wrapped count would crawl through tens
  // of thousands of steps, so such a start is turned into the spare op.
  function automatic in_item_t noise_tick(axis_state_t s, cfg_t c);
    in_item_t it;
    it = in_item_t'(IN_BITS'($urandom));
    if (s.ph == PH_IDLE && it.op == OP_CENTER &&
        (int'(s.cnt1) > int'(c.target) + 64 || int'(s.cnt2) > int'(c.target) + 64)) begin
      it.op = OP_SPARE;
    end
    return it;
  endfunction

  task automatic queue_tick(input in_item_t it);
    tick_q.push_back(it);
    plan_st = homing_tick(plan_st, it, model_cfg);
  endtask

  task automatic random_burst(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) queue_tick(noise_tick(plan_st, model_cfg));
      else queue_tick(plant_tick(plan_st, model_cfg, 1'b1));
    end
  endtask

  // Feeds plant ticks until any running sequence has returned to idle.
  task automatic settle_sequence();
    int guard;
    guard = 0;
    while (plan_st.ph != PH_IDLE && guard < 5000) begin
      queue_tick(plant_tick(plan_st, model_cfg, 1'b0));
      guard++;
    end
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || s_axis_tvalid || status_q.size() != 0) @(posedge clk_i);
  endtask

  // All three registers go in on consecutive edges; the block is idle here.
  task automatic load_config(input logic [COUNT_WIDTH-1:0] tgt, input logic [TIMER_WIDTH-1:0] brk,
                             input logic [TIMER_WIDTH-1:0] cst);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_TARGET;
    cfg_wdata_i <= CFG_WIDTH'(tgt);
    @(negedge clk_i);
    cfg_idx_i   <= REG_BRAKE;
    cfg_wdata_i <= CFG_WIDTH'(brk);
    @(negedge clk_i);
    cfg_idx_i   <= REG_COAST;
    cfg_wdata_i <= CFG_WIDTH'(cst);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    model_cfg = '{target: tgt, brake: brk, coast: cst};
  endtask

  task automatic next_setting(input logic [COUNT_WIDTH-1:0] tgt,
                              input logic [TIMER_WIDTH-1:0] brk,
                              input logic [TIMER_WIDTH-1:0] cst, input int idle, input int stall);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    load_config(tgt, brk, cst);
    idle_pct  = idle;
    stall_pct = stall;
  endtask

  task automatic flag_error(input string what, input longint got, input longint want);
    $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
    error_cnt++;
  endtask

  // ---------------------------------------------------------------------
  // Sender: offers the oldest pending tick at the falling edge, and only
  // moves on once the previous transfer has been seen at the rising edge.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin : tick_driver
    in_item_t nxt;
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = tick_q.pop_front();
        s_axis_tdata  <= {{(IN_TDATA_W-IN_BITS){1'b0}}, nxt};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long hold-off of the receiver, counted here so that the sender carries
  // on offering ticks until the block fills up and pushes back.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      hold_left    <= LONG_HOLD;
      holds_served <= holds_served + 1;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------
  // Monitor: every accepted tick adds one owed status; every result transfer
  // is compared field by field with the oldest one.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : status_monitor
    status_t got;
    status_t want;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (!rst_ni) begin
      pred_st = reset_state();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pred_st = homing_tick(pred_st, in_item_t'(s_axis_tdata[IN_BITS-1:0]), model_cfg);
        status_q.push_back(status_of(pred_st));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = status_t'(m_axis_tdata[OUT_BITS-1:0]);
        if (status_q.size() == 0) begin
          flag_error("status with nothing owed", longint'(got), longint'(0));
        end else begin
          want = status_q.pop_front();
          if (got.drive1 !== want.drive1)
            flag_error("drive1", longint'(got.drive1), longint'(want.drive1));
          if (got.drive2 !== want.drive2)
            flag_error("drive2", longint'(got.drive2), longint'(want.drive2));
          if (got.pos1 !== want.pos1)
            flag_error("pos1", longint'(got.pos1), longint'(want.pos1));
          if (got.pos2 !== want.pos2)
            flag_error("pos2", longint'(got.pos2), longint'(want.pos2));
          if (got.busy !== want.busy)
            flag_error("busy_res", longint'(got.busy), longint'(want.busy));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Run plan: a directed opening, then random phases under different
  // settings and idling, ending on the widest register values.
  // ---------------------------------------------------------------------
  initial begin
    plan_st   = reset_state();
    model_cfg = '{target: TARGET_RESET, brake: BRAKE_RESET, coast: COAST_RESET};
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero target and zero brake and coast: sequences collapse to their
    // shortest form. No idling on either side.
    load_config('0, '0, '0);
    // Spare op with every line high, which arms both encoders.
    queue_tick(tick_of(OP_SPARE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    // Axis one counts up, axis two counts down through zero and wraps.
    queue_tick(tick_of(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
    // Both limits clear the counts while the encoders re-arm.
    queue_tick(tick_of(OP_TICK, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    // Limit held during an edge: the clear comes first, then the step.
    queue_tick(tick_of(OP_TICK, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    // Every field low, fault included.
    queue_tick(tick_of(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    // Recenter with both axes on target: nothing to drive, straight to brake.
    queue_tick(tick_of(OP_CENTER, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
    // Starts while a sequence runs are ignored.
    queue_tick(tick_of(OP_HOME, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
    queue_tick(tick_of(OP_CENTER, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
    // Homing with axis one already at its limit.
    queue_tick(tick_of(OP_HOME, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1));
    // A fault freezes the bridges while the counts still move.
    queue_tick(tick_of(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    queue_tick(tick_of(OP_TICK, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    settle_sequence();
    random_burst(180);
    settle_sequence();

    // Sender idle about half the time.
    next_setting(16'd12, 24'd3, 24'd5, 50, 0);
    // Axis one walked up to the target exactly, axis two left at zero, then a
    // recenter: axis one is held and only axis two drives.
    queue_tick(tick_of(OP_TICK, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    for (int i = 0; i < 24; i++) begin
      queue_tick(tick_of(OP_TICK, i[0], 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
    end
    queue_tick(tick_of(OP_CENTER, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
    settle_sequence();
    random_burst(270);
    settle_sequence();

    // Receiver stalling about half the time.
    next_setting(16'd30, 24'd20, 24'd1, 0, 50);
    random_burst(270);
    settle_sequence();

    // Light idling on both sides; halfway through the sender pauses until
    // every owed status has arrived.
    next_setting(16'($urandom_range(40, 1)), 24'($urandom_range(30)), 24'($urandom_range(30)),
                 10, 10);
    random_burst(135);
    wait_drained();
    random_burst(135);
    settle_sequence();

    // No idling, but one long receiver hold-off so that the block backs up.
    next_setting(16'($urandom_range(40, 1)), 24'($urandom_range(30)), 24'($urandom_range(30)),
                 0, 0);
    holds_asked = holds_asked + 1;
    random_burst(270);
    settle_sequence();

    // Widest register values. A sequence started here never finishes within
    // the run, which is harmless as nothing is written afterwards.
    next_setting('1, '1, '1, 10, 10);
    random_burst(250);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
rtl/tehc_pkg.sv
rtl/tehc_counter.sv
rtl/tehc_sequencer.sv
rtl/two_axis_encoder_homing_controller.sv
tb/testbench.sv
